@@ rtl/core/hjbp_pkg.sv @@
// ----------------------------------------------------------------------------
// hjbp_pkg
// Types, codes and constants shared by the hash-join build/probe engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hjbp_pkg;

  localparam int KEY_W   = 64;
  localparam int CFG_W   = 11;
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 2;

  localparam int DEF_BUCKETS     = 1024;
  localparam int DEF_CAPACITY    = 4096;
  localparam int DEF_MAX_MATCHES = 64;

  localparam logic [CFG_W-1:0] BCNT_RESET = 11'd1024;

  // Multiplier constants of the 64-bit murmur3 finalizer.
  localparam logic [KEY_W-1:0] FMIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;

  localparam logic [ACT_W-1:0] ACT_BUILD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PROBE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TRUNC = 2'd2;

  typedef enum logic [1:0] {
    PH_CHAIN  = 2'd0,
    PH_SECOND = 2'd1,
    PH_FIRST  = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_BRD,
    ST_BROW,
    ST_LINK,
    ST_ISS,
    ST_DAT,
    ST_FIN,
    ST_ACK
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/hash_join_build_probe.sv @@
// ----------------------------------------------------------------------------
// hash_join_build_probe
// Chained hash table with build, probe and clear transactions.
// ----------------------------------------------------------------------------
//
//  channel | handshake                | payload
//  --------+--------------------------+------------------------------------------
//  input   | in_valid_i / in_ready_o  | action_i, key_i, value_i
//  output  | out_valid_o / out_ready_i| match_key_o, build_value_o, probe_value_o,
//          |                          | found_o, last_o, status_o
//  config  | cfg_valid_i / cfg_ready_o| cfg_bucket_count_i
//
//  Build and probe first run the finalizer on one shared 32x32 multiplier
//  and a restoring remainder by the bucket count. A build then reads the
//  bucket, writes the entry and bucket row, links a non-empty chain's old
//  tail to it and acknowledges; a probe reads the bucket, issues and checks
//  each chain entry, re-reads the first two entries and gives the final
//  result. A clear sweeps the bucket table; the same sweep runs after
//  reset, while in_ready_o is low. Output stalls hold the walk in place.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_join_build_probe #(
  parameter int BUCKETS     = hjbp_pkg::DEF_BUCKETS,
  parameter int CAPACITY    = hjbp_pkg::DEF_CAPACITY,
  parameter int MAX_MATCHES = hjbp_pkg::DEF_MAX_MATCHES
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [hjbp_pkg::CFG_W-1:0]    cfg_bucket_count_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [hjbp_pkg::ACT_W-1:0]    action_i,
  input  wire logic [hjbp_pkg::KEY_W-1:0]    key_i,
  input  wire logic [hjbp_pkg::KEY_W-1:0]    value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [hjbp_pkg::KEY_W-1:0]         match_key_o,
  output logic [hjbp_pkg::KEY_W-1:0]         build_value_o,
  output logic [hjbp_pkg::KEY_W-1:0]         probe_value_o,
  output logic                               found_o,
  output logic                               last_o,
  output logic [hjbp_pkg::STAT_W-1:0]        status_o
);

  localparam int NW = $clog2(BUCKETS + 1);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int EW = $clog2(CAPACITY);
  localparam int SW = $clog2(CAPACITY + 1);
  localparam int CW = $clog2(MAX_MATCHES + 1);
  localparam int KW = hjbp_pkg::KEY_W;

  // Memories.
  logic [SW-1:0] bsz_mem [BUCKETS];
  logic [EW-1:0] bfst_mem [BUCKETS];
  logic [EW-1:0] btl_mem [BUCKETS];
  logic [KW-1:0] key_mem [CAPACITY];
  logic [KW-1:0] val_mem [CAPACITY];
  logic [EW-1:0] lnk_mem [CAPACITY];

  logic          bkt_we, bkt_re;
  logic [BW-1:0] bkt_addr;
  logic [SW-1:0] bkt_wsz;
  logic [EW-1:0] bkt_wfst, bkt_wtl;
  logic [SW-1:0] bsz_rd_q;
  logic [EW-1:0] bfst_rd_q, btl_rd_q;

  logic          kv_we, lnk_we, ent_re;
  logic [EW-1:0] kv_waddr, lnk_waddr, lnk_wdata, ent_raddr;
  logic [KW-1:0] key_rd_q, val_rd_q;
  logic [EW-1:0] lnk_rd_q;

  // Control state.
  hjbp_pkg::state_e state_q, state_d;
  hjbp_pkg::phase_e phase_q, phase_d;
  logic [hjbp_pkg::CFG_W-1:0] bcnt_q;
  logic [BW-1:0] clr_q, clr_d;
  logic          clr_ack_q, clr_ack_d;
  logic [SW-1:0] used_q, used_d;
  logic          rnd_q, rnd_d;
  logic [1:0]    hs_q, hs_d;
  logic [5:0]    bc_q, bc_d;
  logic [SW-1:0] i_q, i_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pend_q, pend_d;
  logic          trunc_q, trunc_d;
  logic          out_valid_q, out_valid_d;

  // Payload state.
  logic [hjbp_pkg::ACT_W-1:0]  act_q, act_d;
  logic [KW-1:0] key_q, key_d, val_q, val_d;
  logic [KW-1:0] x_q, x_d, acc_q, acc_d, prod_q, prod_d;
  logic [KW-1:0] mix;
  logic [NW-1:0] rem_q, rem_d;
  logic [SW-1:0] n_q, n_d;
  logic [EW-1:0] cur_q, cur_d, e0_q, e0_d, e1_q, e1_d;
  logic [KW-1:0] pbv_q, pbv_d;
  logic [hjbp_pkg::STAT_W-1:0] st_q, st_d;
  logic [KW-1:0] omk_q, omk_d, obv_q, obv_d, opv_q, opv_d;
  logic          ofound_q, ofound_d, olast_q, olast_d;
  logic [hjbp_pkg::STAT_W-1:0] ostat_q, ostat_d;

  logic [NW-1:0] nb;
  logic [NW:0]   r2;
  logic [31:0]   mul_a, mul_b;
  logic [KW-1:0] mconst;
  logic          out_free, hit, advance;

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == hjbp_pkg::ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign match_key_o   = omk_q;
  assign build_value_o = obv_q;
  assign probe_value_o = opv_q;
  assign found_o       = ofound_q;
  assign last_o        = olast_q;
  assign status_o      = ostat_q;
  assign out_free      = !out_valid_q || out_ready_i;

  // Effective bucket count: zero acts as one, too large acts as BUCKETS.
  always_comb begin
    if (bcnt_q == '0) begin
      nb = NW'(1);
    end else if (32'(bcnt_q) > BUCKETS) begin
      nb = NW'(BUCKETS);
    end else begin
      nb = NW'(bcnt_q);
    end
  end

  assign mconst = rnd_q ? hjbp_pkg::FMIX_C2 : hjbp_pkg::FMIX_C1;
  assign mul_a  = (hs_q == 2'd2) ? x_q[63:32] : x_q[31:0];
  assign mul_b  = (hs_q == 2'd1) ? mconst[63:32] : mconst[31:0];
  assign mix    = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
  assign r2     = {rem_q, x_q[KW-1]};

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    clr_d       = clr_q;
    clr_ack_d   = clr_ack_q;
    used_d      = used_q;
    rnd_d       = rnd_q;
    hs_d        = hs_q;
    bc_d        = bc_q;
    i_d         = i_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    trunc_d     = trunc_q;
    act_d       = act_q;
    key_d       = key_q;
    val_d       = val_q;
    x_d         = x_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    n_d         = n_q;
    cur_d       = cur_q;
    e0_d        = e0_q;
    e1_d        = e1_q;
    pbv_d       = pbv_q;
    st_d        = st_q;
    omk_d       = omk_q;
    obv_d       = obv_q;
    opv_d       = opv_q;
    ofound_d    = ofound_q;
    olast_d     = olast_q;
    ostat_d     = ostat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    bkt_we      = 1'b0;
    bkt_re      = 1'b0;
    bkt_addr    = rem_q[BW-1:0];
    bkt_wsz     = '0;
    bkt_wfst    = '0;
    bkt_wtl     = '0;
    kv_we       = 1'b0;
    lnk_we      = 1'b0;
    ent_re      = 1'b0;
    kv_waddr    = used_q[EW-1:0];
    lnk_waddr   = used_q[EW-1:0];
    lnk_wdata   = '0;
    ent_raddr   = cur_q;
    hit         = 1'b0;
    advance     = 1'b1;

    case (state_q)
      hjbp_pkg::ST_CLR: begin
        bkt_we   = 1'b1;
        bkt_addr = clr_q;
        if (clr_q == BW'(BUCKETS - 1)) begin
          used_d  = '0;
          state_d = clr_ack_q ? hjbp_pkg::ST_ACK : hjbp_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      hjbp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          act_d = action_i;
          key_d = key_i;
          val_d = value_i;
          x_d   = key_i ^ (key_i >> 33);
          rnd_d = 1'b0;
          hs_d  = 2'd0;
          case (action_i)
            hjbp_pkg::ACT_BUILD, hjbp_pkg::ACT_PROBE: state_d = hjbp_pkg::ST_HASH;
            hjbp_pkg::ACT_CLEAR: begin
              clr_d     = '0;
              clr_ack_d = 1'b1;
              state_d   = hjbp_pkg::ST_CLR;
            end
            default: state_d = hjbp_pkg::ST_IDLE;
          endcase
        end
      end

      // Each 64-bit product keeps its low half: lo*lo plus both cross terms.
      hjbp_pkg::ST_HASH: begin
        prod_d = 64'(mul_a) * 64'(mul_b);
        hs_d   = hs_q + 2'd1;
        case (hs_q)
          2'd1: acc_d = prod_q;
          2'd2: acc_d = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
          2'd3: begin
            x_d = mix ^ (mix >> 33);
            if (rnd_q) begin
              rem_d   = '0;
              bc_d    = '0;
              state_d = hjbp_pkg::ST_MOD;
            end else begin
              rnd_d = 1'b1;
            end
          end
          default: acc_d = acc_q;
        endcase
      end

      // Restoring remainder, one hash bit per cycle, most significant first.
      hjbp_pkg::ST_MOD: begin
        x_d = {x_q[KW-2:0], 1'b0};
        if (r2 >= {1'b0, nb}) begin
          rem_d = NW'(r2 - {1'b0, nb});
        end else begin
          rem_d = NW'(r2);
        end
        bc_d = bc_q + 6'd1;
        if (bc_q == 6'd63) begin
          state_d = hjbp_pkg::ST_BRD;
        end
      end

      hjbp_pkg::ST_BRD: begin
        bkt_re  = 1'b1;
        state_d = hjbp_pkg::ST_BROW;
      end

      hjbp_pkg::ST_BROW: begin
        if (act_q == hjbp_pkg::ACT_BUILD) begin
          if (used_q == SW'(CAPACITY)) begin
            st_d    = hjbp_pkg::STAT_FULL;
            state_d = hjbp_pkg::ST_ACK;
          end else begin
            kv_we    = 1'b1;
            lnk_we   = 1'b1;
            bkt_we   = 1'b1;
            bkt_wsz  = bsz_rd_q + 1'b1;
            bkt_wfst = (bsz_rd_q == '0) ? used_q[EW-1:0] : bfst_rd_q;
            bkt_wtl  = used_q[EW-1:0];
            cur_d    = btl_rd_q;
            used_d   = used_q + 1'b1;
            st_d     = hjbp_pkg::STAT_OK;
            state_d  = (bsz_rd_q == '0) ? hjbp_pkg::ST_ACK : hjbp_pkg::ST_LINK;
          end
        end else begin
          n_d     = bsz_rd_q;
          e0_d    = bfst_rd_q;
          cur_d   = bfst_rd_q;
          i_d     = '0;
          phase_d = hjbp_pkg::PH_CHAIN;
          cnt_d   = '0;
          pend_d  = 1'b0;
          trunc_d = 1'b0;
          state_d = (bsz_rd_q == '0) ? hjbp_pkg::ST_FIN : hjbp_pkg::ST_ISS;
        end
      end

      // Hook the new entry onto the old tail of its chain.
      hjbp_pkg::ST_LINK: begin
        lnk_we    = 1'b1;
        lnk_waddr = cur_q;
        lnk_wdata = EW'(used_q - 1'b1);
        state_d   = hjbp_pkg::ST_ACK;
      end

      hjbp_pkg::ST_ISS: begin
        ent_re  = 1'b1;
        state_d = hjbp_pkg::ST_DAT;
      end

      // The first two chain entries are only stepped through here and are
      // tested at the end, second before first.
      hjbp_pkg::ST_DAT: begin
        hit = ((phase_q != hjbp_pkg::PH_CHAIN) || (i_q >= SW'(2))) && (key_rd_q == key_q);
        if (hit) begin
          if (cnt_q == CW'(MAX_MATCHES)) begin
            trunc_d = 1'b1;
            advance = 1'b0;
            state_d = hjbp_pkg::ST_FIN;
          end else if (pend_q) begin
            if (out_free) begin
              out_valid_d = 1'b1;
              omk_d       = key_q;
              obv_d       = pbv_q;
              opv_d       = val_q;
              ofound_d    = 1'b1;
              olast_d     = 1'b0;
              ostat_d     = hjbp_pkg::STAT_OK;
              pbv_d       = val_rd_q;
              cnt_d       = cnt_q + 1'b1;
            end else begin
              advance = 1'b0;
            end
          end else begin
            pend_d = 1'b1;
            pbv_d  = val_rd_q;
            cnt_d  = cnt_q + 1'b1;
          end
        end
        if (advance) begin
          state_d = hjbp_pkg::ST_ISS;
          case (phase_q)
            hjbp_pkg::PH_CHAIN: begin
              if (i_q == SW'(1)) begin
                e1_d = cur_q;
              end
              if ({1'b0, i_q} + 1'b1 < {1'b0, n_q}) begin
                cur_d = lnk_rd_q;
                i_d   = i_q + 1'b1;
              end else if (n_q > SW'(1)) begin
                phase_d = hjbp_pkg::PH_SECOND;
                cur_d   = (i_q == SW'(1)) ? cur_q : e1_q;
              end else begin
                phase_d = hjbp_pkg::PH_FIRST;
                cur_d   = e0_q;
              end
            end
            hjbp_pkg::PH_SECOND: begin
              phase_d = hjbp_pkg::PH_FIRST;
              cur_d   = e0_q;
            end
            default: state_d = hjbp_pkg::ST_FIN;
          endcase
        end
      end

      // The held-back match, if any, becomes the last result of the probe.
      hjbp_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          omk_d       = key_q;
          opv_d       = val_q;
          olast_d     = 1'b1;
          ofound_d    = pend_q;
          obv_d       = pend_q ? pbv_q : '0;
          ostat_d     = trunc_q ? hjbp_pkg::STAT_TRUNC : hjbp_pkg::STAT_OK;
          state_d     = hjbp_pkg::ST_IDLE;
        end
      end

      hjbp_pkg::ST_ACK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ofound_d    = 1'b0;
          olast_d     = 1'b1;
          opv_d       = '0;
          if (act_q == hjbp_pkg::ACT_BUILD) begin
            omk_d   = key_q;
            obv_d   = val_q;
            ostat_d = st_q;
          end else begin
            omk_d   = '0;
            obv_d   = '0;
            ostat_d = hjbp_pkg::STAT_OK;
          end
          clr_ack_d = 1'b0;
          state_d   = hjbp_pkg::ST_IDLE;
        end
      end

      default: state_d = hjbp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hjbp_pkg::ST_CLR;
      phase_q     <= hjbp_pkg::PH_CHAIN;
      bcnt_q      <= hjbp_pkg::BCNT_RESET;
      clr_q       <= '0;
      clr_ack_q   <= 1'b0;
      used_q      <= '0;
      rnd_q       <= 1'b0;
      hs_q        <= '0;
      bc_q        <= '0;
      i_q         <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      trunc_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      if (cfg_valid_i) begin
        bcnt_q <= cfg_bucket_count_i;
      end
      clr_q       <= clr_d;
      clr_ack_q   <= clr_ack_d;
      used_q      <= used_d;
      rnd_q       <= rnd_d;
      hs_q        <= hs_d;
      bc_q        <= bc_d;
      i_q         <= i_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      trunc_q     <= trunc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    key_q    <= key_d;
    val_q    <= val_d;
    x_q      <= x_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    n_q      <= n_d;
    cur_q    <= cur_d;
    e0_q     <= e0_d;
    e1_q     <= e1_d;
    pbv_q    <= pbv_d;
    st_q     <= st_d;
    omk_q    <= omk_d;
    obv_q    <= obv_d;
    opv_q    <= opv_d;
    ofound_q <= ofound_d;
    olast_q  <= olast_d;
    ostat_q  <= ostat_d;
  end

  always_ff @(posedge clk_i) begin
    if (bkt_we) begin
      bsz_mem[bkt_addr]  <= bkt_wsz;
      bfst_mem[bkt_addr] <= bkt_wfst;
      btl_mem[bkt_addr]  <= bkt_wtl;
    end
    if (bkt_re) begin
      bsz_rd_q  <= bsz_mem[bkt_addr];
      bfst_rd_q <= bfst_mem[bkt_addr];
      btl_rd_q  <= btl_mem[bkt_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (kv_we) begin
      key_mem[kv_waddr] <= key_q;
      val_mem[kv_waddr] <= val_q;
    end
    if (ent_re) begin
      key_rd_q <= key_mem[ent_raddr];
      val_rd_q <= val_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lnk_we) begin
      lnk_mem[lnk_waddr] <= lnk_wdata;
    end
    if (ent_re) begin
      lnk_rd_q <= lnk_mem[ent_raddr];
    end
  end

endmodule

`default_nettype wire
